// ===== hw/rtl/igof_pkg.sv =====
// shared types, codes and the micro-op table of the imu orientation filter
`default_nettype none

package igof_pkg;

  // fixed-point constants
  localparam int unsigned QW_BITS  = 32;
  localparam int unsigned VEC_BITS = 40;
  localparam int unsigned F_BITS   = 34;
  localparam int unsigned ACC_BITS = 66;
  localparam int unsigned MA_BITS  = 39;
  localparam int unsigned MB_BITS  = 34;
  localparam int unsigned PRD_BITS = MA_BITS + MB_BITS;

  localparam logic signed [F_BITS-1:0]  ONE_Q30  = F_BITS'(64'sd1073741824);
  localparam logic signed [MA_BITS-1:0] RATE_MAX = {1'b0, {(MA_BITS-1){1'b1}}};
  localparam logic signed [MA_BITS-1:0] RATE_MIN = {1'b1, {(MA_BITS-1){1'b0}}};

  // register reset values
  localparam logic [15:0] BETA_RESET = 16'd5944;
  localparam logic [23:0] STEP_RESET = 24'd167772;

  // register indexes
  localparam logic REG_BETA = 1'b0;
  localparam logic REG_STEP = 1'b1;

  // operand pool codes
  localparam logic [3:0] OPD_QW  = 4'd0;
  localparam logic [3:0] OPD_QX  = 4'd1;
  localparam logic [3:0] OPD_QY  = 4'd2;
  localparam logic [3:0] OPD_QZ  = 4'd3;
  localparam logic [3:0] OPD_ONE = 4'd4;
  localparam logic [3:0] OPD_A0  = 4'd5;
  localparam logic [3:0] OPD_A1  = 4'd6;
  localparam logic [3:0] OPD_A2  = 4'd7;
  localparam logic [3:0] OPD_F0  = 4'd8;
  localparam logic [3:0] OPD_F1  = 4'd9;
  localparam logic [3:0] OPD_F2  = 4'd10;
  localparam logic [3:0] OPD_GX  = 4'd11;
  localparam logic [3:0] OPD_GY  = 4'd12;
  localparam logic [3:0] OPD_GZ  = 4'd13;

  // accumulate coefficient codes
  localparam logic [1:0] COEF_P1 = 2'd0;
  localparam logic [1:0] COEF_M1 = 2'd1;
  localparam logic [1:0] COEF_P2 = 2'd2;
  localparam logic [1:0] COEF_M2 = 2'd3;

  // accumulator destination codes
  localparam logic [3:0] DST_NONE = 4'd0;
  localparam logic [3:0] DST_F0   = 4'd1;
  localparam logic [3:0] DST_F1   = 4'd2;
  localparam logic [3:0] DST_F2   = 4'd3;
  localparam logic [3:0] DST_V0   = 4'd4;
  localparam logic [3:0] DST_V1   = 4'd5;
  localparam logic [3:0] DST_V2   = 4'd6;
  localparam logic [3:0] DST_V3   = 4'd7;
  localparam logic [3:0] DST_RATE = 4'd8;

  // first micro-op of the gyro term
  localparam logic [4:0] UOP_GYRO = 5'd20;

  // normalize pass owner
  localparam logic [1:0] PH_ACC  = 2'd0;
  localparam logic [1:0] PH_GRAD = 2'd1;
  localparam logic [1:0] PH_QUAT = 2'd2;

  typedef struct packed {
    logic [3:0] sel_a;
    logic [3:0] sel_b;
    logic [1:0] coef;
    logic       shr;
    logic       first;
    logic       last;
    logic [3:0] dest;
  } uop_t;

  function automatic uop_t mk(input logic [3:0] sa, input logic [3:0] sb,
                              input logic [1:0] cf, input logic sh,
                              input logic fs, input logic ls, input logic [3:0] ds);
    uop_t u;
    u.sel_a = sa;
    u.sel_b = sb;
    u.coef  = cf;
    u.shr   = sh;
    u.first = fs;
    u.last  = ls;
    u.dest  = ds;
    return u;
  endfunction

  // objective, gradient and gyro products as multiply-accumulate steps
  function automatic uop_t uop_rom(input logic [4:0] idx);
    uop_t u;
    case (idx)
      5'd0:  u = mk(OPD_QX,  OPD_QZ,  COEF_P2, 1'b1, 1'b1, 1'b0, DST_NONE);
      5'd1:  u = mk(OPD_QW,  OPD_QY,  COEF_M2, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd2:  u = mk(OPD_A0,  OPD_ONE, COEF_M1, 1'b1, 1'b0, 1'b1, DST_F0);
      5'd3:  u = mk(OPD_QW,  OPD_QX,  COEF_P2, 1'b1, 1'b1, 1'b0, DST_NONE);
      5'd4:  u = mk(OPD_QY,  OPD_QZ,  COEF_P2, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd5:  u = mk(OPD_A1,  OPD_ONE, COEF_M1, 1'b1, 1'b0, 1'b1, DST_F1);
      5'd6:  u = mk(OPD_ONE, OPD_ONE, COEF_P1, 1'b1, 1'b1, 1'b0, DST_NONE);
      5'd7:  u = mk(OPD_QX,  OPD_QX,  COEF_M2, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd8:  u = mk(OPD_QY,  OPD_QY,  COEF_M2, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd9:  u = mk(OPD_A2,  OPD_ONE, COEF_M1, 1'b1, 1'b0, 1'b1, DST_F2);
      5'd10: u = mk(OPD_QX,  OPD_F1,  COEF_P1, 1'b1, 1'b1, 1'b0, DST_NONE);
      5'd11: u = mk(OPD_QY,  OPD_F0,  COEF_M1, 1'b1, 1'b0, 1'b1, DST_V0);
      5'd12: u = mk(OPD_QZ,  OPD_F0,  COEF_P1, 1'b1, 1'b1, 1'b0, DST_NONE);
      5'd13: u = mk(OPD_QW,  OPD_F1,  COEF_P1, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd14: u = mk(OPD_QX,  OPD_F2,  COEF_M2, 1'b1, 1'b0, 1'b1, DST_V1);
      5'd15: u = mk(OPD_QZ,  OPD_F1,  COEF_P1, 1'b1, 1'b1, 1'b0, DST_NONE);
      5'd16: u = mk(OPD_QY,  OPD_F2,  COEF_M2, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd17: u = mk(OPD_QW,  OPD_F0,  COEF_M1, 1'b1, 1'b0, 1'b1, DST_V2);
      5'd18: u = mk(OPD_QX,  OPD_F0,  COEF_P1, 1'b1, 1'b1, 1'b0, DST_NONE);
      5'd19: u = mk(OPD_QY,  OPD_F1,  COEF_P1, 1'b1, 1'b0, 1'b1, DST_V3);
      5'd20: u = mk(OPD_QX,  OPD_GX,  COEF_M1, 1'b0, 1'b1, 1'b0, DST_NONE);
      5'd21: u = mk(OPD_QY,  OPD_GY,  COEF_M1, 1'b0, 1'b0, 1'b0, DST_NONE);
      5'd22: u = mk(OPD_QZ,  OPD_GZ,  COEF_M1, 1'b0, 1'b0, 1'b1, DST_RATE);
      5'd23: u = mk(OPD_QW,  OPD_GX,  COEF_P1, 1'b0, 1'b1, 1'b0, DST_NONE);
      5'd24: u = mk(OPD_QY,  OPD_GZ,  COEF_P1, 1'b0, 1'b0, 1'b0, DST_NONE);
      5'd25: u = mk(OPD_QZ,  OPD_GY,  COEF_M1, 1'b0, 1'b0, 1'b1, DST_RATE);
      5'd26: u = mk(OPD_QW,  OPD_GY,  COEF_P1, 1'b0, 1'b1, 1'b0, DST_NONE);
      5'd27: u = mk(OPD_QX,  OPD_GZ,  COEF_M1, 1'b0, 1'b0, 1'b0, DST_NONE);
      5'd28: u = mk(OPD_QZ,  OPD_GX,  COEF_P1, 1'b0, 1'b0, 1'b1, DST_RATE);
      5'd29: u = mk(OPD_QW,  OPD_GZ,  COEF_P1, 1'b0, 1'b1, 1'b0, DST_NONE);
      5'd30: u = mk(OPD_QX,  OPD_GY,  COEF_P1, 1'b0, 1'b0, 1'b0, DST_NONE);
      default: u = mk(OPD_QY, OPD_GX, COEF_M1, 1'b0, 1'b0, 1'b1, DST_RATE);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/imu_gradient_orientation_filter.sv =====
// imu orientation filter: gradient-descent quaternion update per six-axis sample
//
// input channel: in_valid / in_stall carry one sample (gyro, accel, stamp);
// a transfer happens when in_valid is high and in_stall is low. output channel:
// out_valid / out_stall carry the new orientation quaternion and the stamp.
// gain_beta (offset 0) and step_period (offset 4) sit on the apb port; the user
// must write them only while the filter is idle; the block does not enforce it.
// one sample at a time: in_stall stays high from the transfer until the result
// is loaded into the output register. three vector normalizations each need a
// 32-step bit-serial square root and a 31-step radix-2 divide per component,
// plus passes through the single shared multiplier for the objective, gradient
// and gyro terms.
// the output register frees the datapath: the next sample is taken while a
// result waits; if the receiver still stalls when the next result is ready,
// the filter holds it internally and keeps in_stall high.
// reset (synchronous, rst high) sets the orientation to the unit quaternion,
// restores the register defaults and drops out_valid.
`default_nettype none

module imu_gradient_orientation_filter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] gyro_x,
  input  wire logic signed [31:0] gyro_y,
  input  wire logic signed [31:0] gyro_z,
  input  wire logic signed [31:0] accel_x,
  input  wire logic signed [31:0] accel_y,
  input  wire logic signed [31:0] accel_z,
  input  wire logic [31:0]        stamp,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      quat_w,
  output logic signed [31:0]      quat_x,
  output logic signed [31:0]      quat_y,
  output logic signed [31:0]      quat_z,
  output logic [31:0]             stamp_out
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_NMAX  = 4'd1;
  localparam logic [3:0] S_NSHF  = 4'd2;
  localparam logic [3:0] S_NSQM  = 4'd3;
  localparam logic [3:0] S_NSQA  = 4'd4;
  localparam logic [3:0] S_NSQRT = 4'd5;
  localparam logic [3:0] S_NDIVI = 4'd6;
  localparam logic [3:0] S_NDIV  = 4'd7;
  localparam logic [3:0] S_NRET  = 4'd8;
  localparam logic [3:0] S_UMUL  = 4'd9;
  localparam logic [3:0] S_UACC  = 4'd10;
  localparam logic [3:0] S_BMUL  = 4'd11;
  localparam logic [3:0] S_BACC  = 4'd12;
  localparam logic [3:0] S_RMUL  = 4'd13;
  localparam logic [3:0] S_RACC  = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  localparam int unsigned VB = igof_pkg::VEC_BITS;
  localparam int unsigned AB = igof_pkg::ACC_BITS;

  logic [3:0]  state;
  logic [1:0]  phase;
  logic [15:0] gain_beta;
  logic [23:0] step_period;

  // orientation and per-sample operands
  logic signed [31:0]                  q [4];
  logic signed [31:0]                  a [3];
  logic signed [igof_pkg::F_BITS-1:0]  f [3];
  logic signed [31:0]                  gyr [3];
  logic [31:0]                         stamp_hold;
  logic signed [VB-1:0]                vreg [4];

  // shared multiplier and accumulator
  logic signed [igof_pkg::MA_BITS-1:0]  mul_a;
  logic signed [igof_pkg::MB_BITS-1:0]  mul_b;
  logic signed [igof_pkg::PRD_BITS-1:0] prod;
  logic signed [igof_pkg::PRD_BITS-1:0] prod_r;
  logic signed [AB-1:0]                 acc;

  // micro-op sequencer
  logic [4:0]           up;
  logic [1:0]           ci;
  igof_pkg::uop_t       uop;
  logic signed [igof_pkg::F_BITS-1:0] opa;
  logic signed [igof_pkg::F_BITS-1:0] opb;
  logic signed [AB-1:0] term;
  logic signed [AB-1:0] scaled;
  logic signed [AB-1:0] acc_next;

  // normalize unit
  logic [1:0]    nv_idx;
  logic          nlen4;
  logic [1:0]    last_idx;
  logic [VB-1:0] nm;
  logic [VB-1:0] nm_next;
  logic [3:0]    ns;
  logic signed [VB-1:0] cur_v;
  logic [VB-1:0] cur_mag;
  logic [30:0]   cur_c;
  logic [63:0]   sq_x;
  logic [63:0]   sq_res;
  logic [63:0]   sq_bit;
  logic [63:0]   sq_t;
  logic          sq_ge;
  logic [31:0]   nrm;
  logic [32:0]   dv_rem;
  logic [32:0]   dv_diff;
  logic          dv_ge;
  logic [29:0]   dv_quot;
  logic [30:0]   dv_qn;
  logic [4:0]    dv_cnt;
  logic signed [VB-1:0] dv_val;

  // rate path
  logic signed [igof_pkg::MA_BITS-1:0] rate_sat;
  logic signed [AB-1:0] bacc_next;
  logic signed [VB-1:0] racc_val;
  logic                 out_load;

  // config port
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      igof_pkg::REG_BETA: prdata = {16'd0, gain_beta};
      igof_pkg::REG_STEP: prdata = {8'd0, step_period};
      default:            prdata = 32'd0;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // operand pool selection
  function automatic logic signed [igof_pkg::F_BITS-1:0] pool(input logic [3:0] sel,
      input logic signed [31:0] qw, input logic signed [31:0] qx,
      input logic signed [31:0] qy, input logic signed [31:0] qz,
      input logic signed [31:0] a0, input logic signed [31:0] a1,
      input logic signed [31:0] a2, input logic signed [igof_pkg::F_BITS-1:0] f0,
      input logic signed [igof_pkg::F_BITS-1:0] f1,
      input logic signed [igof_pkg::F_BITS-1:0] f2, input logic signed [31:0] gx,
      input logic signed [31:0] gy, input logic signed [31:0] gz);
    logic signed [igof_pkg::F_BITS-1:0] r;
    unique case (sel)
      igof_pkg::OPD_QW:  r = igof_pkg::F_BITS'(qw);
      igof_pkg::OPD_QX:  r = igof_pkg::F_BITS'(qx);
      igof_pkg::OPD_QY:  r = igof_pkg::F_BITS'(qy);
      igof_pkg::OPD_QZ:  r = igof_pkg::F_BITS'(qz);
      igof_pkg::OPD_ONE: r = igof_pkg::ONE_Q30;
      igof_pkg::OPD_A0:  r = igof_pkg::F_BITS'(a0);
      igof_pkg::OPD_A1:  r = igof_pkg::F_BITS'(a1);
      igof_pkg::OPD_A2:  r = igof_pkg::F_BITS'(a2);
      igof_pkg::OPD_F0:  r = f0;
      igof_pkg::OPD_F1:  r = f1;
      igof_pkg::OPD_F2:  r = f2;
      igof_pkg::OPD_GX:  r = igof_pkg::F_BITS'(gx);
      igof_pkg::OPD_GY:  r = igof_pkg::F_BITS'(gy);
      igof_pkg::OPD_GZ:  r = igof_pkg::F_BITS'(gz);
      default:           r = '0;
    endcase
    return r;
  endfunction

  assign uop = igof_pkg::uop_rom(up);
  assign opa = pool(uop.sel_a, q[0], q[1], q[2], q[3], a[0], a[1], a[2],
                    f[0], f[1], f[2], gyr[0], gyr[1], gyr[2]);
  assign opb = pool(uop.sel_b, q[0], q[1], q[2], q[3], a[0], a[1], a[2],
                    f[0], f[1], f[2], gyr[0], gyr[1], gyr[2]);

  // normalize helpers
  assign last_idx = nlen4 ? 2'd3 : 2'd2;
  assign cur_v    = vreg[nv_idx];
  assign cur_mag  = cur_v[VB-1] ? VB'(-cur_v) : VB'(cur_v);
  assign cur_c    = 31'(cur_mag >> ns);
  assign nm_next  = (cur_mag > nm) ? cur_mag : nm;
  assign sq_t     = sq_res + sq_bit;
  assign sq_ge    = (sq_x >= sq_t);
  assign dv_diff  = dv_rem - {1'b0, nrm};
  assign dv_ge    = (dv_rem >= {1'b0, nrm});
  assign dv_qn    = {dv_quot, dv_ge};
  assign dv_val   = cur_v[VB-1] ? -VB'({1'b0, dv_qn}) : VB'({1'b0, dv_qn});

  // rate saturation to the q30 range of about 256 per second
  always_comb begin
    if (acc[AB-1:54] == {(AB-54){acc[54]}}) begin
      rate_sat = $signed(acc[54:16]);
    end else if (acc[AB-1]) begin
      rate_sat = igof_pkg::RATE_MIN;
    end else begin
      rate_sat = igof_pkg::RATE_MAX;
    end
  end

  // shared multiplier operand selection
  always_comb begin
    case (state)
      S_NSQM: begin
        mul_a = igof_pkg::MA_BITS'({1'b0, cur_c});
        mul_b = igof_pkg::MB_BITS'({1'b0, cur_c});
      end
      S_BMUL: begin
        mul_a = igof_pkg::MA_BITS'(vreg[ci]);
        mul_b = igof_pkg::MB_BITS'({1'b0, gain_beta});
      end
      S_RMUL: begin
        mul_a = rate_sat;
        mul_b = igof_pkg::MB_BITS'({1'b0, step_period});
      end
      default: begin
        mul_a = igof_pkg::MA_BITS'(opa);
        mul_b = opb;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // multiply-accumulate term
  always_comb begin
    if (uop.shr) begin
      term = AB'(prod_r >>> 30);
    end else begin
      term = $signed(prod_r[AB-1:0]);
    end
    case (uop.coef)
      igof_pkg::COEF_P1: scaled = term;
      igof_pkg::COEF_M1: scaled = -term;
      igof_pkg::COEF_P2: scaled = term <<< 1;
      default:           scaled = -(term <<< 1);
    endcase
    acc_next = (uop.first ? AB'(0) : acc) + scaled;
  end

  assign bacc_next = (acc >>> 1) - $signed(prod_r[AB-1:0]);
  assign racc_val  = VB'(q[ci]) + $signed(prod_r[63:24]);
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      phase       <= igof_pkg::PH_ACC;
      gain_beta   <= igof_pkg::BETA_RESET;
      step_period <= igof_pkg::STEP_RESET;
      q[0]        <= 32'sd1073741824;
      q[1]        <= '0;
      q[2]        <= '0;
      q[3]        <= '0;
      out_valid   <= 1'b0;
      up          <= '0;
      ci          <= '0;
      nv_idx      <= '0;
      nlen4       <= 1'b0;
    end else begin
      // register write transfer
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[2])
          igof_pkg::REG_BETA: gain_beta   <= pwdata[15:0];
          igof_pkg::REG_STEP: step_period <= pwdata[23:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            gyr[0]     <= gyro_x;
            gyr[1]     <= gyro_y;
            gyr[2]     <= gyro_z;
            stamp_hold <= stamp;
            vreg[0]    <= VB'(accel_x);
            vreg[1]    <= VB'(accel_y);
            vreg[2]    <= VB'(accel_z);
            vreg[3]    <= '0;
            phase      <= igof_pkg::PH_ACC;
            nlen4      <= 1'b0;
            nm         <= '0;
            nv_idx     <= '0;
            state      <= S_NMAX;
          end
        end

        // largest magnitude, one component a cycle
        S_NMAX: begin
          nm <= nm_next;
          if (nv_idx == last_idx) begin
            nv_idx <= '0;
            ns     <= '0;
            state  <= (nm_next == '0) ? S_NRET : S_NSHF;
          end else begin
            nv_idx <= nv_idx + 2'd1;
          end
        end

        // shift until the largest magnitude fits 31 bits
        S_NSHF: begin
          if (nm[VB-1:31] != '0) begin
            nm <= nm >> 1;
            ns <= ns + 4'd1;
          end else begin
            acc   <= '0;
            state <= S_NSQM;
          end
        end

        S_NSQM: begin
          prod_r <= prod;
          state  <= S_NSQA;
        end

        S_NSQA: begin
          acc <= acc + AB'(prod_r);
          if (nv_idx == last_idx) begin
            sq_x   <= 64'(acc + AB'(prod_r));
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            nv_idx <= '0;
            state  <= S_NSQRT;
          end else begin
            nv_idx <= nv_idx + 2'd1;
            state  <= S_NSQM;
          end
        end

        // bit-serial square root
        S_NSQRT: begin
          if (sq_bit != '0) begin
            if (sq_ge) begin
              sq_x   <= sq_x - sq_t;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end else begin
            nrm   <= sq_res[31:0];
            state <= S_NDIVI;
          end
        end

        S_NDIVI: begin
          dv_rem  <= {2'b00, cur_c};
          dv_quot <= '0;
          dv_cnt  <= 5'd30;
          state   <= S_NDIV;
        end

        // restoring divide, one quotient bit a cycle
        S_NDIV: begin
          dv_quot <= dv_qn[29:0];
          dv_rem  <= dv_ge ? {dv_diff[31:0], 1'b0} : {dv_rem[31:0], 1'b0};
          if (dv_cnt == '0) begin
            vreg[nv_idx] <= dv_val;
            if (nv_idx == last_idx) begin
              state <= S_NRET;
            end else begin
              nv_idx <= nv_idx + 2'd1;
              state  <= S_NDIVI;
            end
          end else begin
            dv_cnt <= dv_cnt - 5'd1;
          end
        end

        // hand the normalized vector to its owner
        S_NRET: begin
          unique case (phase)
            igof_pkg::PH_ACC: begin
              a[0]  <= vreg[0][31:0];
              a[1]  <= vreg[1][31:0];
              a[2]  <= vreg[2][31:0];
              up    <= '0;
              state <= S_UMUL;
            end
            igof_pkg::PH_GRAD: begin
              up    <= igof_pkg::UOP_GYRO;
              ci    <= '0;
              state <= S_UMUL;
            end
            default: begin
              q[0]  <= vreg[0][31:0];
              q[1]  <= vreg[1][31:0];
              q[2]  <= vreg[2][31:0];
              q[3]  <= vreg[3][31:0];
              state <= S_DONE;
            end
          endcase
        end

        S_UMUL: begin
          prod_r <= prod;
          state  <= S_UACC;
        end

        S_UACC: begin
          acc   <= acc_next;
          up    <= up + 5'd1;
          state <= S_UMUL;
          if (uop.last) begin
            case (uop.dest)
              igof_pkg::DST_F0: f[0] <= acc_next[igof_pkg::F_BITS-1:0];
              igof_pkg::DST_F1: f[1] <= acc_next[igof_pkg::F_BITS-1:0];
              igof_pkg::DST_F2: f[2] <= acc_next[igof_pkg::F_BITS-1:0];
              igof_pkg::DST_V0: vreg[0] <= acc_next[VB-1:0];
              igof_pkg::DST_V1: vreg[1] <= acc_next[VB-1:0];
              igof_pkg::DST_V2: vreg[2] <= acc_next[VB-1:0];
              igof_pkg::DST_V3: begin
                vreg[3] <= acc_next[VB-1:0];
                phase   <= igof_pkg::PH_GRAD;
                nlen4   <= 1'b1;
                nm      <= '0;
                nv_idx  <= '0;
                state   <= S_NMAX;
              end
              igof_pkg::DST_RATE: state <= S_BMUL;
              default: ;
            endcase
          end
        end

        S_BMUL: begin
          prod_r <= prod;
          state  <= S_BACC;
        end

        // half the gyro term less beta times the gradient
        S_BACC: begin
          acc   <= bacc_next;
          state <= S_RMUL;
        end

        S_RMUL: begin
          prod_r <= prod;
          state  <= S_RACC;
        end

        // integrate over the step period
        S_RACC: begin
          vreg[ci] <= racc_val;
          if (ci == 2'd3) begin
            phase  <= igof_pkg::PH_QUAT;
            nlen4  <= 1'b1;
            nm     <= '0;
            nv_idx <= '0;
            state  <= S_NMAX;
          end else begin
            ci    <= ci + 2'd1;
            state <= S_UMUL;
          end
        end

        S_DONE: begin
          if (out_load) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      quat_w    <= q[0];
      quat_x    <= q[1];
      quat_y    <= q[2];
      quat_z    <= q[3];
      stamp_out <= stamp_hold;
    end
  end

  // an accepted sample closes the input until its result is out
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a sample is in flight");

  // the divider never sees a zero norm
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_NDIV) |-> (nrm != 32'd0))
    else $error("normalize divide by zero");

  // a fresh result is a normalized quaternion component
  a_quat_range: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> (quat_w <= 32'sd1073741824 && quat_w >= -32'sd1073741824))
    else $error("quaternion out of range");

endmodule

`default_nettype wire
